@@ rtl/core/tkm_pkg.sv @@
// Package for the thresholded extreme-K mean block: sizes, register
// indexes, word types and sequencer states. Depends on nothing.
`timescale 1ns / 1ps

package tkm_pkg;

   // List depth and derived widths
   localparam int MAX_KEEP = 64;
   localparam int KEEP_W   = $clog2(MAX_KEEP + 1);
   localparam int ADDR_W   = $clog2(MAX_KEEP);
   localparam int COORD_W  = 32;
   localparam int SUM_W    = COORD_W + ADDR_W + 1;
   localparam int MAG_W    = SUM_W - 1;
   localparam int STEP_W   = $clog2(MAG_W + 1);
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Y_LIMIT       = 2'd0,
      CSR_KEEP_COUNT    = 2'd1,
      CSR_PICK_SMALLEST = 2'd2
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic signed [COORD_W-1:0] mean_x;
      logic [KEEP_W-1:0]         used_count;
   } rsp_word_type;

   // Request to the iterative divider
   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [KEEP_W-1:0]       divisor;
   } div_req_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/core/thresholded_extreme_k_mean.sv @@
// Thresholded extreme-K mean: top level with the list memory, the sequencer
// and the registers. Depends on tkm_pkg and tkm_div.
`timescale 1ns / 1ps
//
// Usage:
// - req_* takes one point word (x, y, last flag). A point with y below the
//   y_limit register is kept in a list of the keep_count smallest x values
//   (pick_smallest = 1) or largest (0); keep_count saturates at 64.
// - On the word flagged last, one rsp_* word carries the truncated mean of
//   the held values and their count (0 and 0 if nothing is held), and the
//   list is emptied for the next cloud.
// - csr_* writes a register (0 y_limit, 1 keep_count, 2 pick_smallest);
//   it is always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this.
// Sequence: scan and shift share the list's one read port. A dropped point
//   skips the scan; any other is compared with the held values in order until
//   it finds its place or the end. If kept, the entries below move down one at
//   a time and the new x is written. A last point then sums the held values,
//   runs the bit-serial divider if any are held and loads the output register.
// Reset (synchronous) empties the list and loads the register defaults;
//   there is no clearing pass. A stalled receiver holds the result in the
//   output register; the next point is still accepted, and a following
//   result waits for the register to free up.

module thresholded_extreme_k_mean
   import tkm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data
);

   // Configuration registers
   logic signed [COORD_W-1:0] y_limit_ff;
   logic [KEEP_W-1:0]         keep_count_ff;
   logic                      pick_smallest_ff;

   // Sequencer and work registers
   state_type                 state_ff, state_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic                      last_ff, last_in;
   logic [KEEP_W-1:0]         k_ff, k_in;
   logic [KEEP_W-1:0]         h_ff, h_in;
   logic [KEEP_W-1:0]         p_ff, p_in;
   logic [KEEP_W-1:0]         idx_ff, idx_in;
   logic [KEEP_W-1:0]         held_ff, held_in;
   logic [KEEP_W-1:0]         n_ff, n_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [COORD_W-1:0] mean_ff, mean_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_data_ff, rsp_data_in;

   // List memory, one write and one registered read port
   logic signed [COORD_W-1:0] list_mem [MAX_KEEP];
   logic signed [COORD_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [COORD_W-1:0] wr_data;

   // Helpers
   logic [KEEP_W-1:0]         eff_k;
   logic [KEEP_W-1:0]         idx_dec;
   logic                      better_hit;
   logic [KEEP_W-1:0]         dec_idx;
   logic [KEEP_W-1:0]         dec_held;
   logic                      dec_drop;
   div_req_type               div_req;
   logic                      div_done;
   logic signed [COORD_W-1:0] div_quot;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_limit_ff       <= '0;
         keep_count_ff    <= KEEP_W'(1);
         pick_smallest_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_Y_LIMIT:       y_limit_ff       <= csr_data;
            CSR_KEEP_COUNT:    keep_count_ff    <= csr_data[KEEP_W-1:0];
            CSR_PICK_SMALLEST: pick_smallest_ff <= csr_data[0];
            default:           ;
         endcase
      end
   end

   // Shared compare and insertion decision
   assign eff_k      = (keep_count_ff > KEEP_W'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP) : keep_count_ff;
   assign idx_dec    = idx_ff - KEEP_W'(1);
   assign better_hit = pick_smallest_ff ? (x_ff < rd_data_ff) : (x_ff > rd_data_ff);
   assign dec_drop   = (p_ff >= k_ff);
   assign dec_idx    = (h_ff < k_ff) ? h_ff : (k_ff - KEEP_W'(1));
   assign dec_held   = (h_ff < k_ff) ? (h_ff + KEEP_W'(1)) : k_ff;

   // Sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = p_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = p_ff[ADDR_W-1:0];
      wr_data      = x_ff;
      div_req      = '{start: 1'b0, dividend: sum_ff, divisor: n_ff};
      req_ready    = 1'b0;

      unique case (state_ff) inside
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x_in    = req_data.point_x;
               last_in = req_data.last_point;
               k_in    = eff_k;
               h_in    = (held_ff < eff_k) ? held_ff : eff_k;
               p_in    = '0;
               state_in = ST_FINISH;
               if (req_data.point_y < y_limit_ff) begin
                  if (eff_k == '0) begin
                     held_in = '0;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD, ST_SCAN_CMP: begin
            // first place where the new x beats the held value, or the end
            if ((state_ff == ST_SCAN_RD && p_ff == h_ff) ||
                (state_ff == ST_SCAN_CMP && better_hit)) begin
               if (dec_drop) begin
                  held_in  = h_ff;
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = dec_idx;
                  held_in  = dec_held;
                  state_in = ST_SHIFT_RD;
               end
            end else if (state_ff == ST_SCAN_RD) begin
               rd_addr  = p_ff[ADDR_W-1:0];
               state_in = ST_SCAN_CMP;
            end else begin
               p_in     = p_ff + KEEP_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_ff == p_ff) begin
               wr_en    = 1'b1;
               wr_addr  = p_ff[ADDR_W-1:0];
               wr_data  = x_ff;
               state_in = ST_FINISH;
            end else begin
               rd_addr  = idx_dec[ADDR_W-1:0];
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            // move one entry down a place
            wr_en    = 1'b1;
            wr_addr  = idx_ff[ADDR_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_dec;
            state_in = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               n_in     = (held_ff < k_ff) ? held_ff : k_ff;
               held_in  = '0;
               sum_in   = '0;
               idx_in   = '0;
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            if (idx_ff == n_ff) begin
               if (n_ff == '0) begin
                  mean_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV_WAIT;
               end
            end else begin
               rd_addr  = idx_ff[ADDR_W-1:0];
               state_in = ST_SUM_ACC;
            end
         end
         ST_SUM_ACC: begin
            sum_in   = sum_ff + SUM_W'(rd_data_ff);
            idx_in   = idx_ff + KEEP_W'(1);
            state_in = ST_SUM_RD;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{mean_x: mean_ff, used_count: n_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      h_ff        <= h_in;
      p_ff        <= p_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      sum_ff      <= sum_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   // List memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= list_mem[rd_addr];
   end

   // Divider for the final mean
   tkm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // the held count never exceeds the list depth
   assert property (@(posedge clock) disable iff (reset) held_ff <= KEEP_W'(MAX_KEEP))
      else $error("tkm: held count above depth");
   // an accepted point makes the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) (req_valid && req_ready) |=> !req_ready)
      else $error("tkm: ready right after accept");
   // the divider reports only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("tkm: divider done out of sequence");
   // an empty result carries a zero mean
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.used_count == '0) |-> (rsp_data_ff.mean_x == '0))
      else $error("tkm: nonzero mean with zero count");
`endif

endmodule

@@ rtl/core/tkm_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tkm_pkg for widths and the request struct.
`timescale 1ns / 1ps

module tkm_div
   import tkm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  div_req_type               div_req,
   output logic                      div_done,
   output logic signed [COORD_W-1:0] div_quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MAG_W-1:0]  q_ff, q_in;
   logic [KEEP_W-1:0] rem_ff, rem_in;
   logic [KEEP_W-1:0] dvs_ff, dvs_in;
   logic [KEEP_W:0]   trial;
   logic [SUM_W-1:0]  mag_full;
   logic [MAG_W-1:0]  q_signed;

   // Magnitude of the dividend and the restoring trial remainder
   assign mag_full = div_req.dividend[SUM_W-1] ? (-div_req.dividend) : div_req.dividend;
   assign trial    = {rem_ff, q_ff[MAG_W-1]};
   assign q_signed = neg_ff ? (-q_ff) : q_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[SUM_W-1];
         q_in    = mag_full[MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         step_in = '0;
      end else if (busy_ff) begin
         // one restoring step: shift in a dividend bit, subtract if it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = KEEP_W'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[KEEP_W-1:0];
            q_in   = {q_ff[MAG_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_done = done_ff;
   assign div_quot = q_signed[COORD_W-1:0];

`ifndef SYNTHESIS
   // a start never lands on a running division
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("tkm_div: start while busy");
   // done only follows a running division
   assert property (@(posedge clock) disable iff (reset) done_in |-> busy_ff)
      else $error("tkm_div: done without a division");
   // the remainder stays below the divisor while running
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !div_req.start |=> (rem_ff < dvs_ff))
      else $error("tkm_div: remainder out of range");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for thresholded_extreme_k_mean: drives point words, predicts the
// mean and count of each cloud, and checks every result word against it.
// Depends on tkm_pkg and on the block's RTL.

module testbench;
   import tkm_pkg::*;

   localparam int     IDLE_WAIT     = 300;        // longest point that emits nothing
   localparam int     HOLD_CYCLES   = 500;        // long receiver hold-off
   localparam int     RANDOM_POINTS = 1000;
   localparam longint CYCLE_LIMIT   = 3_000_000;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

   // Block ports, all known from time zero
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_word_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_word_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_Y_LIMIT;
   logic [COORD_W-1:0]   csr_data  = '0;

   // Shadow registers and extreme list of the predictor
   logic signed [COORD_W-1:0] y_limit_reg  = '0;
   logic [KEEP_W-1:0]         keep_reg     = 7'd1;
   logic                      smallest_reg = 1'b1;
   logic signed [COORD_W-1:0] kept_x [MAX_KEEP];
   int unsigned               kept_count   = 0;

   rsp_word_type expected_means [$];
   req_word_type point_queue [$];

   // Handshake bookkeeping between the clocked processes
   bit     req_taken     = 1'b0;
   bit     rsp_taken     = 1'b0;
   int     send_gap_max  = 0;
   int     recv_gap_max  = 0;
   int     send_wait     = 0;
   int     recv_wait     = 0;
   int     hold_requests = 0;
   int     holds_done    = 0;
   int     hold_left     = 0;
   int     points_taken  = 0;
   int     means_checked = 0;
   int     error_count   = 0;
   int     phase_count   = 0;
   longint cycle_count   = 0;

   thresholded_extreme_k_mean uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Ordering used by the list under the current mode
   function automatic bit ranks_ahead(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b);
      return smallest_reg ? (a < b) : (a > b);
   endfunction

   // Fold one accepted point into the list; on the last point queue the mean
   function automatic void take_point(input req_word_type p);
      int unsigned  limit;
      int unsigned  held;
      int unsigned  pos;
      int unsigned  n;
      int           idx;
      longint       total;
      rsp_word_type r;
      limit = (keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg;
      if (p.point_y < y_limit_reg) begin
         held = (kept_count < limit) ? kept_count : limit;
         pos  = 0;
         while (pos < held && !ranks_ahead(p.point_x, kept_x[pos]))
            pos++;
         // past the end (or keep count zero): entries beyond the limit drop out
         if (pos >= limit) begin
            kept_count = held;
         end else begin
            for (idx = (held < limit) ? held : limit - 1; idx > pos; idx--)
               kept_x[idx] = kept_x[idx-1];
            kept_x[pos] = p.point_x;
            kept_count  = (held < limit) ? held + 1 : limit;
         end
      end
      if (p.last_point) begin
         n     = (kept_count < limit) ? kept_count : limit;
         total = 0;
         for (idx = 0; idx < n; idx++)
            total += kept_x[idx];
         r.mean_x     = (n > 0) ? COORD_W'(total / longint'(n)) : '0;
         r.used_count = KEEP_W'(n);
         expected_means.insert(expected_means.size(), r);
         kept_count = 0;
      end
   endfunction

   function automatic void push_point(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic last);
      req_word_type w;
      w.point_x    = x;
      w.point_y    = y;
      w.last_point = last;
      point_queue.insert(point_queue.size(), w);
   endfunction

   // Random point; most land below the threshold, some right at it
   function automatic void push_random_point(input logic last);
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      longint                    span;
      case ($urandom_range(0, 9))
         0:       x = C_MIN;
         1:       x = C_MAX;
         2, 3:    x = $urandom_range(0, 4) - 2;
         default: x = $urandom;
      endcase
      span = longint'(y_limit_reg) - longint'(C_MIN);
      case ($urandom_range(0, 9))
         0:       y = y_limit_reg;
         1:       y = (span > 0) ? y_limit_reg - 1 : C_MIN;
         2, 3:    y = $urandom;
         default: y = (span > 0) ? COORD_W'(longint'(C_MIN) + longint'($urandom) % span)
                                 : $urandom;
      endcase
      push_point(x, y, last);
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         default: return 13;
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [COORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_Y_LIMIT:       y_limit_reg  = value;
         CSR_KEEP_COUNT:    keep_reg     = value[KEEP_W-1:0];
         CSR_PICK_SMALLEST: smallest_reg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender pause: everything taken, every mean back, block settled
   task automatic wait_idle();
      while (point_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_means.size() != 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   // Point driver: next word from the queue after a drawn gap
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (point_queue.size() != 0) begin
            req_data  <= point_queue.pop_front();
            req_valid <= 1'b1;
            send_wait = $urandom_range(0, send_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: drawn stall per word, plus the long hold on request
   always @(negedge clock) begin
      if (!reset) begin
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            recv_wait = $urandom_range(0, recv_gap_max);
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         if (hold_left > 0)
            hold_left--;
         rsp_ready <= (hold_left == 0 && recv_wait == 0);
      end
   end

   // Monitor: predict on accepted points, check accepted result words
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            take_point(req_data);
            req_taken = 1'b1;
            points_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (expected_means.size() == 0) begin
               $error("unexpected result word: mean_x %0d used_count %0d",
                      rsp_data.mean_x, rsp_data.used_count);
               error_count++;
            end else begin
               want = expected_means.pop_front();
               means_checked++;
               if (rsp_data.mean_x !== want.mean_x) begin
                  $error("mean_x: expected %0d, got %0d", want.mean_x, rsp_data.mean_x);
                  error_count++;
               end
               if (rsp_data.used_count !== want.used_count) begin
                  $error("used_count: expected %0d, got %0d",
                         want.used_count, rsp_data.used_count);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d means still owed",
                  cycle_count, expected_means.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int random_sent;
      int clouds;
      int cloud_len;
      bit open_end;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: keep one smallest x with y below zero
      push_point(C_MAX, -1, 1'b0);
      push_point(C_MIN, -1, 1'b0);
      push_point(0, 0, 1'b0);              // y equal to the threshold is dropped
      push_point(5, C_MIN, 1'b1);
      push_point(7, C_MAX, 1'b1);          // nothing qualifies
      wait_idle();

      // Three largest, with equal values and the threshold at its top
      write_reg(CSR_Y_LIMIT, C_MAX);
      write_reg(CSR_KEEP_COUNT, 32'd3);
      write_reg(CSR_PICK_SMALLEST, 32'd0);
      push_point(10, 0, 1'b0);
      push_point(10, 0, 1'b0);
      push_point(10, 0, 1'b0);
      push_point(C_MAX, C_MAX - 1, 1'b0);
      push_point(C_MIN, C_MAX, 1'b0);
      push_point(10, C_MIN, 1'b1);
      wait_idle();

      // Keep count zero gives an empty mean
      write_reg(CSR_KEEP_COUNT, 32'd0);
      push_point(1, 0, 1'b0);
      push_point(2, 0, 1'b1);
      wait_idle();

      // Saturated keep count, threshold at its bottom: nothing qualifies
      write_reg(CSR_KEEP_COUNT, 32'd127);
      write_reg(CSR_Y_LIMIT, C_MIN);
      push_point(3, C_MIN, 1'b1);
      wait_idle();

      // Keep count lowered in the middle of a cloud
      write_reg(CSR_Y_LIMIT, C_MAX);
      write_reg(CSR_KEEP_COUNT, 32'd4);
      write_reg(CSR_PICK_SMALLEST, 32'd1);
      push_point(40, 0, 1'b0);
      push_point(-31, 0, 1'b0);
      push_point(20, 0, 1'b0);
      push_point(-10, 0, 1'b0);
      wait_idle();
      write_reg(CSR_KEEP_COUNT, 32'd2);
      push_point(0, 0, 1'b1);
      wait_idle();

      // Mode flipped in the middle of a cloud, list not re-sorted
      write_reg(CSR_KEEP_COUNT, 32'd3);
      push_point(5, 0, 1'b0);
      push_point(1, 0, 1'b0);
      push_point(3, 0, 1'b0);
      wait_idle();
      write_reg(CSR_PICK_SMALLEST, 32'd0);
      push_point(4, 0, 1'b0);
      push_point(-100, 0, 1'b1);
      wait_idle();

      // Long receiver hold while points keep coming back to back
      write_reg(CSR_KEEP_COUNT, 32'd64);
      send_gap_max = 0;
      recv_gap_max = 0;
      hold_requests++;
      repeat (40) push_random_point(1'b1);
      wait_idle();

      // Random phases; a phase may end mid-cloud so the next settings apply to it
      while (random_sent < RANDOM_POINTS) begin
         send_gap_max = pick_gap();
         recv_gap_max = pick_gap();
         case ($urandom_range(0, 9))
            0:       write_reg(CSR_Y_LIMIT, C_MIN);
            1:       write_reg(CSR_Y_LIMIT, C_MAX);
            2:       write_reg(CSR_Y_LIMIT, 0);
            3, 4:    write_reg(CSR_Y_LIMIT, $urandom);
            default: write_reg(CSR_Y_LIMIT, $urandom_range(0, 200000) - 100000);
         endcase
         case ($urandom_range(0, 9))
            0:       write_reg(CSR_KEEP_COUNT, 32'd0);
            1:       write_reg(CSR_KEEP_COUNT, 32'd64);
            2:       write_reg(CSR_KEEP_COUNT, 32'd127);
            3:       write_reg(CSR_KEEP_COUNT, $urandom_range(65, 127));
            4, 5:    write_reg(CSR_KEEP_COUNT, $urandom_range(1, 64));
            default: write_reg(CSR_KEEP_COUNT, $urandom_range(1, 8));
         endcase
         write_reg(CSR_PICK_SMALLEST, $urandom_range(0, 1));
         clouds = $urandom_range(1, 6);
         for (int c = 0; c < clouds; c++) begin
            cloud_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                    : $urandom_range(1, 8);
            open_end = (c == clouds - 1) && ($urandom_range(0, 4) == 0);
            for (int j = 0; j < cloud_len; j++)
               push_random_point(j == cloud_len - 1 && !open_end);
            random_sent += cloud_len;
         end
         wait_idle();
         phase_count++;
      end
      push_random_point(1'b1);
      wait_idle();

      $display("%0d points over %0d random phases, %0d result words checked",
               points_taken, phase_count, means_checked);
      $display("covered both modes, keep counts from zero to saturated, mid-cloud changes");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tkm_pkg.sv
rtl/core/tkm_div.sv
rtl/core/thresholded_extreme_k_mean.sv
bench/testbench.sv
